FILE: rtl/smafm_pkg.sv
// ----------------------------------------------------------------------------
// Sensor moving-average fault monitor package
// Shared widths, reset values, register indexes, state codes and the
// control bundle between the top level and the serial divider.
// ----------------------------------------------------------------------------
package smafm_pkg;

   localparam int WINDOW_DEFAULT = 5;
   localparam int SAMPLE_W       = 16;
   localparam int LIMIT_W        = 8;
   localparam int FAILS_W        = 8;
   localparam int PADDR_W        = 3;
   localparam int PDATA_W        = 32;
   localparam int CSR_IDX_W      = 1;

   localparam logic [LIMIT_W-1:0]   LIMIT_RESET       = 8'd5;
   localparam logic [FAILS_W-1:0]   FAILS_MAX         = 8'd255;
   localparam logic [CSR_IDX_W-1:0] CSR_FAILURE_LIMIT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_ADD,
      ST_START,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic negative;
   } div_ctl_type;

endpackage

FILE: rtl/smafm_if.sv
// ----------------------------------------------------------------------------
// Sensor moving-average fault monitor channels
// Valid/ready channels for sensor readings and for monitor results.
// ----------------------------------------------------------------------------
interface smafm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 read_ok;
   logic signed [smafm_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output read_ok, output sample, input ready);
   modport sink   (input valid, input read_ok, input sample, output ready);
endinterface

interface smafm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 average_valid;
   logic signed [smafm_pkg::SAMPLE_W-1:0] average;
   logic                                 sensor_fault;
   logic [smafm_pkg::FAILS_W-1:0]        failures_in_row;

   modport source (output valid, output average_valid, output average,
                   output sensor_fault, output failures_in_row, input ready);
   modport sink   (input valid, input average_valid, input average,
                   input sensor_fault, input failures_in_row, output ready);
endinterface

FILE: rtl/sensor_moving_average_fault_monitor_unit.sv
// ----------------------------------------------------------------------------
// Sensor moving-average fault monitor
// Keeps a ring of recent temperature samples and a running sum, and reports
// the truncated mean on good readings and a sticky fault after a run of
// failed readings.
// ----------------------------------------------------------------------------
// A successful reading passes through the SUB, ADD, START and WAIT states,
// where the bit-serial divider forms the mean, before DONE; a failed
// reading goes from IDLE straight to DONE.
// The next reading is taken only back in IDLE, which DONE enters once the
// output register is free.
// Synchronous reset clears the ring, the sum, the counters and the fault flag.
// ----------------------------------------------------------------------------
module sensor_moving_average_fault_monitor_unit #(
   parameter int WINDOW = smafm_pkg::WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   smafm_req_if.sink                        req_if,
   smafm_rsp_if.source                      rsp_if,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [smafm_pkg::PADDR_W-1:0]    paddr,
   input  logic [smafm_pkg::PDATA_W-1:0]    pwdata,
   output logic [smafm_pkg::PDATA_W-1:0]    prdata,
   output logic                             pready
);
   import smafm_pkg::*;

   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(WINDOW);

   state_type                  state_ff, state_in;

   logic signed [SAMPLE_W-1:0] ring_ff [WINDOW];
   logic [SLOT_W-1:0]          slot_ff;
   logic [CNT_W-1:0]           filled_ff;
   logic [FAILS_W-1:0]         fails_ff;
   logic                       fault_ff;
   logic [LIMIT_W-1:0]         limit_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SAMPLE_W-1:0] new_ff;
   logic signed [SAMPLE_W-1:0] old_ff;

   logic                       pend_avg_valid_ff;
   logic signed [SAMPLE_W-1:0] pend_avg_ff;
   logic                       pend_fault_ff;
   logic [FAILS_W-1:0]         pend_fails_ff;

   logic                       out_valid_ff;
   logic                       out_avg_valid_ff;
   logic signed [SAMPLE_W-1:0] out_avg_ff;
   logic                       out_fault_ff;
   logic [FAILS_W-1:0]         out_fails_ff;

   logic                       accept;
   logic                       load;
   logic [FAILS_W-1:0]         fails_in;
   logic                       fault_in;
   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_index;
   div_ctl_type                div_ctl;
   logic [SUM_W-1:0]           div_magnitude;
   logic                       div_done;
   logic signed [SAMPLE_W-1:0] div_quotient;

   assign accept    = req_if.valid && req_if.ready;
   assign fails_in  = (fails_ff == FAILS_MAX) ? fails_ff : fails_ff + 8'd1;
   assign fault_in  = fault_ff || (fails_in >= limit_ff);
   assign csr_index = paddr[PADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_if.read_ok ? ST_SUB : ST_DONE;
            end
         end
         ST_SUB:   state_in = ST_ADD;
         ST_ADD:   state_in = ST_START;
         ST_START: state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_if.ready     = 1'b0;
      load             = 1'b0;
      div_ctl.start    = 1'b0;
      div_ctl.negative = sum_ff[SUM_W-1];
      div_magnitude    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      case (state_ff)
         ST_IDLE:  req_if.ready  = 1'b1;
         ST_START: div_ctl.start = 1'b1;
         ST_DONE:  load          = !out_valid_ff || rsp_if.ready;
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         filled_ff    <= '0;
         fails_ff     <= '0;
         fault_ff     <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_write && csr_index == CSR_FAILURE_LIMIT) begin
            limit_ff <= pwdata[LIMIT_W-1:0];
         end
         if (accept) begin
            if (req_if.read_ok) begin
               fails_ff        <= '0;
               fault_ff        <= 1'b0;
               ring_ff[slot_ff] <= req_if.sample;
               slot_ff         <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
               if (filled_ff != FULL_COUNT) begin
                  filled_ff <= filled_ff + 1'b1;
               end
            end else begin
               fails_ff <= fails_in;
               fault_ff <= fault_in;
            end
         end
         if (state_ff == ST_SUB) begin
            sum_ff <= sum_ff - SUM_W'(old_ff);
         end
         if (state_ff == ST_ADD) begin
            sum_ff <= sum_ff + SUM_W'(new_ff);
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         new_ff            <= req_if.sample;
         old_ff            <= ring_ff[slot_ff];
         pend_avg_valid_ff <= req_if.read_ok;
         pend_avg_ff       <= '0;
         pend_fault_ff     <= req_if.read_ok ? 1'b0 : fault_in;
         pend_fails_ff     <= req_if.read_ok ? '0 : fails_in;
      end
      if (state_ff == ST_WAIT && div_done) begin
         pend_avg_ff <= div_quotient;
      end
      if (load) begin
         out_avg_valid_ff <= pend_avg_valid_ff;
         out_avg_ff       <= pend_avg_ff;
         out_fault_ff     <= pend_fault_ff;
         out_fails_ff     <= pend_fails_ff;
      end
   end

   smafm_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .magnitude (div_magnitude),
      .divisor   (filled_ff),
      .done      (div_done),
      .quotient  (div_quotient)
   );

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.average_valid   = out_avg_valid_ff;
   assign rsp_if.average         = out_avg_ff;
   assign rsp_if.sensor_fault    = out_fault_ff;
   assign rsp_if.failures_in_row = out_fails_ff;

   assign pready = 1'b1;
   assign prdata = (csr_index == CSR_FAILURE_LIMIT) ? PDATA_W'(limit_ff) : '0;

endmodule

FILE: rtl/smafm_div.sv
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division of a sum magnitude by the sample count, one quotient
// bit per cycle, with the sign applied to the truncated quotient.
// ----------------------------------------------------------------------------
module smafm_div #(
   parameter int SUM_W = 19,
   parameter int CNT_W = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  smafm_pkg::div_ctl_type                ctl,
   input  logic [SUM_W-1:0]                      magnitude,
   input  logic [CNT_W-1:0]                      divisor,
   output logic                                  done,
   output logic signed [smafm_pkg::SAMPLE_W-1:0] quotient
);
   import smafm_pkg::*;

   localparam int BIT_W = $clog2(SUM_W + 1);
   localparam logic [BIT_W-1:0] BIT_COUNT = BIT_W'(SUM_W);
   localparam logic [BIT_W-1:0] BIT_LAST  = BIT_W'(1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [BIT_W-1:0]    bits_ff, bits_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    div_ff, div_in;
   logic                neg_ff, neg_in;

   logic [CNT_W:0]      shifted;
   logic [CNT_W:0]      diff;
   logic                take;
   logic [SAMPLE_W-1:0] quo_low;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign take    = shifted >= {1'b0, div_ff};
   assign quo_low = quo_ff[SAMPLE_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bits_in = bits_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         bits_in = BIT_COUNT;
         rem_in  = '0;
         quo_in  = magnitude;
         div_in  = divisor;
         neg_in  = ctl.negative;
      end else if (busy_ff) begin
         rem_in  = take ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in  = {quo_ff[SUM_W-2:0], take};
         bits_in = bits_ff - BIT_LAST;
         if (bits_ff == BIT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bits_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bits_ff <= bits_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_low : quo_low;

endmodule

FILE: rtl/smafm_checker.sv
// ----------------------------------------------------------------------------
// Sensor moving-average fault monitor checker
// Port-level checks on result consistency, the result channel and the
// register port, bound to the top level.
// ----------------------------------------------------------------------------
module smafm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic                                  rsp_average_valid,
   input logic signed [smafm_pkg::SAMPLE_W-1:0] rsp_average,
   input logic                                  rsp_sensor_fault,
   input logic [smafm_pkg::FAILS_W-1:0]         rsp_failures_in_row,
   input logic                                  pready
);
   import smafm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average)
         && $stable(rsp_failures_in_row) && $stable(rsp_average_valid))
      else $error("Result changed while its transfer was stalled.");

   a_fail_zero_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_average_valid |-> rsp_average == '0)
      else $error("Failed reading carried a nonzero average.");

   a_good_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_average_valid |-> !rsp_sensor_fault
         && rsp_failures_in_row == '0)
      else $error("Good reading left the failure state set.");

   a_fail_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_average_valid |-> rsp_failures_in_row != '0)
      else $error("Failed reading did not advance the failure count.");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("Register port stalled.");

endmodule

bind sensor_moving_average_fault_monitor_unit smafm_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_average_valid   (rsp_if.average_valid),
   .rsp_average         (rsp_if.average),
   .rsp_sensor_fault    (rsp_if.sensor_fault),
   .rsp_failures_in_row (rsp_if.failures_in_row),
   .pready              (pready)
);
